/* rtl/zrts_pkg.sv */
// zrts_pkg: shared codes, reset values and control types of the zone relay scheduler
// used by every module under rtl/, depends on nothing

package zrts_pkg;

  localparam int IDX_W = 6;   // covers the largest slot count
  localparam int MIN_W = 11;  // minute of day
  localparam int DAY_W = 9;
  localparam int BTN_ZONES = 6;

  localparam logic [2:0] MODE_TICK    = 3'd0;
  localparam logic [2:0] MODE_TICK_TS = 3'd1;
  localparam logic [2:0] MODE_MANUAL  = 3'd2;
  localparam logic [2:0] MODE_WRITE   = 3'd3;
  localparam logic [2:0] MODE_DELETE  = 3'd4;
  localparam logic [2:0] MODE_RESYNC  = 3'd5;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_REJECT  = 2'd1;
  localparam logic [1:0] ST_EMPTY   = 2'd2;

  localparam logic [1:0] REG_AUTO   = 2'd0;
  localparam logic [1:0] REG_DEB    = 2'd1;
  localparam logic [1:0] REG_MDEF   = 2'd2;
  localparam logic [1:0] REG_TMASK  = 2'd3;

  localparam logic [DAY_W-1:0] NEVER_DAY = 9'd511;
  localparam logic [MIN_W-1:0] NO_MINUTE = 11'd2047;
  localparam logic [31:0]      MS_PER_S  = 32'd1000;

  typedef struct packed {
    logic             load;    // latch the item
    logic             expire;  // deadline check of zone idx
    logic             check;   // decide on the schedule pass
    logic             sched;   // evaluate slot idx
    logic             btn;     // debounce zone idx
    logic             single;  // one-cycle command
    logic             finish;  // register the result
    logic [IDX_W-1:0] idx;
  } cmd_t;

  typedef struct packed {
    logic is_tick;
    logic sched_go;
  } stat_t;

endpackage

/* rtl/zrts_ctrl.sv */
// zrts_ctrl: sequencer that walks zones and slots for one item
// depends on zrts_pkg

module zrts_ctrl #(
  parameter int ZONES = 6,
  parameter int SLOTS = 16
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  output logic           busy,
  input  zrts_pkg::stat_t stat,
  output zrts_pkg::cmd_t  cmd
);
  import zrts_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_OP    = 3'd1;
  localparam logic [2:0] S_EXP   = 3'd2;
  localparam logic [2:0] S_CHK   = 3'd3;
  localparam logic [2:0] S_SCHED = 3'd4;
  localparam logic [2:0] S_BTN   = 3'd5;
  localparam logic [2:0] S_DONE  = 3'd6;

  logic [2:0]       state, state_next;
  logic [IDX_W-1:0] cnt, cnt_next;
  logic             last_zone, last_slot;

  assign last_zone = (cnt == IDX_W'(ZONES - 1));
  assign last_slot = (cnt == IDX_W'(SLOTS - 1));
  assign busy = (state != S_IDLE);

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    cmd        = '0;
    cmd.idx    = cnt;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          cnt_next   = '0;
          state_next = S_OP;
        end
      end
      S_OP: begin
        if (stat.is_tick) begin
          state_next = S_EXP;
        end else begin
          cmd.single = 1'b1;
          state_next = S_DONE;
        end
      end
      S_EXP: begin
        cmd.expire = 1'b1;
        cnt_next   = cnt + 1'b1;
        if (last_zone) begin
          cnt_next   = '0;
          state_next = S_CHK;
        end
      end
      S_CHK: begin
        cmd.check  = 1'b1;
        state_next = stat.sched_go ? S_SCHED : S_BTN;
      end
      S_SCHED: begin
        cmd.sched = 1'b1;
        cnt_next  = cnt + 1'b1;
        if (last_slot) begin
          cnt_next   = '0;
          state_next = S_BTN;
        end
      end
      S_BTN: begin
        cmd.btn  = 1'b1;
        cnt_next = cnt + 1'b1;
        if (last_zone) begin
          cnt_next   = '0;
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        cmd.finish = 1'b1;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCHED) |-> (cnt < IDX_W'(SLOTS))) else $error("slot walk out of range");
  a_finish_one: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |=> !busy) else $error("finish not followed by idle");
  a_load_busy: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> busy) else $error("load did not start the sequence");

endmodule

/* rtl/zrts_dp.sv */
// zrts_dp: zone, button and schedule state plus the shared zone drive logic
// depends on zrts_pkg, steered by zrts_ctrl

module zrts_dp #(
  parameter int ZONES = 6,
  parameter int SLOTS = 16
) (
  input  logic           clk,
  input  logic           rst,
  input  zrts_pkg::cmd_t  cmd,
  output zrts_pkg::stat_t stat,
  input  logic           auto_enabled,
  input  logic [15:0]    debounce_ms,
  input  logic [22:0]    manual_default_s,
  input  logic [5:0]     timed_zone_mask,
  input  logic [2:0]     mode,
  input  logic [31:0]    now_ms,
  input  logic [5:0]     buttons,
  input  logic [4:0]     hour,
  input  logic [5:0]     minute,
  input  logic [2:0]     weekday,
  input  logic [8:0]     year_day,
  input  logic [2:0]     zone,
  input  logic           turn_on,
  input  logic [22:0]    on_secs,
  input  logic [3:0]     slot,
  input  logic [6:0]     days_mask,
  output logic           done,
  output logic [5:0]     relays,
  output logic [5:0]     manual_flags,
  output logic           override_active,
  output logic           state_changed,
  output logic [1:0]     status
);
  import zrts_pkg::*;

  localparam int ZW = (ZONES > 1) ? $clog2(ZONES) : 1;
  localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  // latched item
  logic [2:0]  m_mode;
  logic [31:0] m_now;
  logic [5:0]  m_btn;
  logic [4:0]  m_hour;
  logic [5:0]  m_min;
  logic [2:0]  m_wday;
  logic [8:0]  m_yday;
  logic [2:0]  m_zone;
  logic        m_on;
  logic [22:0] m_dur;
  logic [3:0]  m_slot;
  logic [6:0]  m_days;

  logic [ZONES-1:0] zone_on, zone_manual, btn_stable, btn_last;
  logic [31:0]      zone_deadline [ZONES];
  logic [31:0]      btn_time [ZONES];
  logic [SLOTS-1:0] slot_valid;
  logic [DAY_W-1:0] slot_last_day [SLOTS];
  logic [MIN_W-1:0] last_minute;
  logic [2:0]       e_zone [SLOTS];
  logic [4:0]       e_hour [SLOTS];
  logic [5:0]       e_min  [SLOTS];
  logic [22:0]      e_dur  [SLOTS];
  logic [6:0]       e_days [SLOTS];
  logic             chg;
  logic [1:0]       st;

  logic [ZW-1:0]    zi;
  logic [SW-1:0]    si, wsi;
  logic [MIN_W-1:0] mod;
  logic             zone_ok, slot_ok, slot_hit, ezone_ok;
  logic             wr_ok;

  assign zi  = cmd.idx[ZW-1:0];
  assign si  = cmd.idx[SW-1:0];
  assign wsi = 7'({3'b0, m_slot}) < 7'(SLOTS) ? SW'({3'b0, m_slot}) : '0;
  assign mod = MIN_W'(m_hour) * MIN_W'(60) + MIN_W'(m_min);
  assign zone_ok  = ({1'b0, m_zone} < 4'(ZONES));
  assign slot_ok  = ({3'b0, m_slot} < 7'(SLOTS));
  assign ezone_ok = ({1'b0, e_zone[si]} < 4'(ZONES));
  assign slot_hit = slot_valid[si] && (m_wday <= 3'd6) && e_days[si][m_wday] &&
                    (e_hour[si] == m_hour) && (e_min[si] == m_min) &&
                    (slot_last_day[si] != m_yday);
  assign wr_ok = slot_ok && zone_ok && (m_hour <= 5'd23) && (m_min <= 6'd59) &&
                 (m_dur != '0) && (m_days != '0);

  assign stat.is_tick  = (m_mode == MODE_TICK) || (m_mode == MODE_TICK_TS);
  assign stat.sched_go = (m_mode == MODE_TICK_TS) && auto_enabled && (|slot_valid) &&
                         (mod != last_minute);

  // button walk for zone zi
  logic        lvl, lvl_diff, btn_fire;
  logic [31:0] ct_eff, btn_age;
  assign lvl      = ({1'b0, zi} < 4'(BTN_ZONES)) ? m_btn[3'(zi)] : 1'b1;
  assign lvl_diff = (lvl != btn_last[zi]);
  assign ct_eff   = lvl_diff ? m_now : btn_time[zi];
  assign btn_age  = m_now - ct_eff;
  assign btn_fire = (btn_age >= {16'b0, debounce_ms}) && (lvl != btn_stable[zi]);

  // expiry check for zone zi
  logic [31:0] dl_diff;
  assign dl_diff = zone_deadline[zi] - m_now;

  // shared zone drive
  logic          drv_en, drv_on, drv_man;
  logic [ZW-1:0] drv_z;
  logic [22:0]   drv_secs, tgt;
  logic [31:0]   dl_new, dl_cur;
  logic          timed, drv_chg;

  always_comb begin
    drv_en   = 1'b0;
    drv_z    = zi;
    drv_on   = 1'b0;
    drv_man  = 1'b0;
    drv_secs = '0;
    if (cmd.expire) begin
      drv_en = (zone_deadline[zi] != '0) && ((dl_diff == '0) || dl_diff[31]);
    end else if (cmd.sched) begin
      drv_en   = slot_hit && ezone_ok;
      drv_z    = ZW'({1'b0, e_zone[si]});
      drv_on   = 1'b1;
      drv_secs = e_dur[si];
    end else if (cmd.btn) begin
      drv_en  = btn_fire && !lvl;
      drv_on  = !zone_on[zi];
      drv_man = 1'b1;
    end else if (cmd.single) begin
      drv_en   = (m_mode == MODE_MANUAL) && zone_ok;
      drv_z    = ZW'({1'b0, m_zone});
      drv_on   = m_on;
      drv_man  = 1'b1;
      drv_secs = m_dur;
    end
  end

  assign timed  = ({1'b0, drv_z} < 4'(BTN_ZONES)) && timed_zone_mask[3'(drv_z)];
  assign tgt    = (drv_secs == '0 && drv_man && timed) ? manual_default_s : drv_secs;
  assign dl_new = (tgt != '0) ? m_now + {9'b0, tgt} * MS_PER_S : 32'd0;
  assign dl_cur = zone_deadline[drv_z];

  always_comb begin
    if (drv_on) begin
      drv_chg = (zone_on[drv_z] != 1'b1) || (zone_manual[drv_z] != drv_man) ||
                (dl_cur != dl_new);
    end else begin
      drv_chg = zone_on[drv_z] || (dl_cur != '0) || zone_manual[drv_z];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      m_mode <= mode;      m_now  <= now_ms;   m_btn  <= buttons;
      m_hour <= hour;      m_min  <= minute;   m_wday <= weekday;
      m_yday <= year_day;  m_zone <= zone;     m_on   <= turn_on;
      m_dur  <= on_secs;   m_slot <= slot;     m_days <= days_mask;
    end
    if (cmd.single && m_mode == MODE_WRITE && wr_ok) begin
      e_zone[wsi] <= m_zone;
      e_hour[wsi] <= m_hour;
      e_min[wsi]  <= m_min;
      e_dur[wsi]  <= m_dur;
      e_days[wsi] <= m_days;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      zone_on     <= '0;
      zone_manual <= '0;
      btn_stable  <= '1;
      btn_last    <= '1;
      slot_valid  <= '0;
      last_minute <= NO_MINUTE;
      chg         <= 1'b0;
      st          <= ST_OK;
      done        <= 1'b0;
      for (int i = 0; i < ZONES; i++) begin
        zone_deadline[i] <= '0;
        btn_time[i]      <= '0;
      end
      for (int i = 0; i < SLOTS; i++) slot_last_day[i] <= NEVER_DAY;
    end else begin
      done <= cmd.finish;
      if (cmd.load) begin
        chg <= 1'b0;
        st  <= ST_OK;
      end
      if (drv_en) begin
        chg <= chg | drv_chg;
        zone_on[drv_z] <= drv_on;
        zone_manual[drv_z] <= drv_on ? drv_man : 1'b0;
        zone_deadline[drv_z] <= drv_on ? dl_new : 32'd0;
      end
      if (cmd.check && stat.sched_go) last_minute <= mod;
      if (cmd.sched && slot_hit) slot_last_day[si] <= m_yday;
      if (cmd.btn) begin
        if (lvl_diff) begin
          btn_last[zi] <= lvl;
          btn_time[zi] <= m_now;
        end
        if (btn_fire) btn_stable[zi] <= lvl;
      end
      if (cmd.single) begin
        case (m_mode)
          MODE_WRITE: begin
            if (wr_ok) begin
              slot_valid[wsi]    <= 1'b1;
              slot_last_day[wsi] <= NEVER_DAY;
            end else begin
              st <= ST_REJECT;
            end
          end
          MODE_DELETE: begin
            if (slot_ok && slot_valid[wsi]) slot_valid[wsi] <= 1'b0;
            else st <= ST_EMPTY;
          end
          MODE_RESYNC: begin
            last_minute <= NO_MINUTE;
            for (int i = 0; i < SLOTS; i++) slot_last_day[i] <= NEVER_DAY;
          end
          default: ;
        endcase
      end
    end
  end

  // result register
  logic [5:0] on6, man6;
  always_comb begin
    on6  = '0;
    man6 = '0;
    for (int i = 0; i < BTN_ZONES; i++) begin
      if (i < ZONES) begin
        on6[i]  = zone_on[i];
        man6[i] = zone_manual[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      relays          <= on6;
      manual_flags    <= man6;
      override_active <= |(zone_on & zone_manual);
      state_changed   <= chg;
      status          <= st;
    end
  end

  a_off_clean: assert property (@(posedge clk) disable iff (rst)
    (drv_en && !drv_on) |=> !zone_manual[$past(drv_z)]) else $error("off left manual flag");
  a_status_tick: assert property (@(posedge clk) disable iff (rst)
    (cmd.finish && stat.is_tick) |-> (st == ST_OK)) else $error("tick with error status");
  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done) else $error("result strobe longer than one cycle");

endmodule

/* rtl/zone_relay_timer_scheduler_top.sv */
// zone_relay_timer_scheduler_top: apb registers and the sequencer/datapath pair
// depends on zrts_pkg, zrts_ctrl, zrts_dp

// One command per transfer: start is taken when busy is low, and after the work
// the result shows for exactly one cycle with done high; the receiver cannot
// stall it. Manual, slot write, slot delete and resync commands are handled in a
// single step. A tick checks the zones for expiry one per cycle, then, when a
// schedule pass is due, walks the slots one per cycle through the single zone
// drive unit, then debounces the buttons one zone per cycle. Configuration is
// written over the apb port at byte offsets 0, 4, 8 and 12, and the user must write
// it only while the block is idle; the block itself does not enforce this.

module zone_relay_timer_scheduler_top #(
  parameter int ZONES = 6,
  parameter int SLOTS = 16
) (
  input  logic        clk,
  input  logic        rst,
  // apb configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // command transfer
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  mode,
  input  logic [31:0] now_ms,
  input  logic [5:0]  buttons,
  input  logic [4:0]  hour,
  input  logic [5:0]  minute,
  input  logic [2:0]  weekday,
  input  logic [8:0]  year_day,
  input  logic [2:0]  zone,
  input  logic        turn_on,
  input  logic [22:0] on_secs,
  input  logic [3:0]  slot,
  input  logic [6:0]  days_mask,
  // result transfer
  output logic        done,
  output logic [5:0]  relays,
  output logic [5:0]  manual_flags,
  output logic        override_active,
  output logic        state_changed,
  output logic [1:0]  status
);
  import zrts_pkg::*;

  logic        auto_enabled;
  logic [15:0] debounce_ms;
  logic [22:0] manual_default_s;
  logic [5:0]  timed_zone_mask;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  // register file, written in the access phase
  always_ff @(posedge clk) begin
    if (rst) begin
      auto_enabled     <= 1'b1;
      debounce_ms      <= 16'd50;
      manual_default_s <= 23'd900;
      timed_zone_mask  <= 6'd15;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_AUTO:  auto_enabled     <= pwdata[0];
        REG_DEB:   debounce_ms      <= pwdata[15:0];
        REG_MDEF:  manual_default_s <= pwdata[22:0];
        REG_TMASK: timed_zone_mask  <= pwdata[5:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_AUTO:  prdata = {31'b0, auto_enabled};
      REG_DEB:   prdata = {16'b0, debounce_ms};
      REG_MDEF:  prdata = {9'b0, manual_default_s};
      REG_TMASK: prdata = {26'b0, timed_zone_mask};
      default:   prdata = '0;
    endcase
  end

  cmd_t  cmd;
  stat_t stat;

  zrts_ctrl #(.ZONES(ZONES), .SLOTS(SLOTS)) u_ctrl (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .stat(stat), .cmd(cmd)
  );

  zrts_dp #(.ZONES(ZONES), .SLOTS(SLOTS)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .stat(stat),
    .auto_enabled(auto_enabled), .debounce_ms(debounce_ms),
    .manual_default_s(manual_default_s), .timed_zone_mask(timed_zone_mask),
    .mode(mode), .now_ms(now_ms), .buttons(buttons), .hour(hour), .minute(minute),
    .weekday(weekday), .year_day(year_day), .zone(zone), .turn_on(turn_on),
    .on_secs(on_secs), .slot(slot), .days_mask(days_mask),
    .done(done), .relays(relays), .manual_flags(manual_flags),
    .override_active(override_active), .state_changed(state_changed), .status(status)
  );

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy) else $error("accepted command did not raise busy");
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy) else $error("result while still busy");
  a_ovr: assert property (@(posedge clk) disable iff (rst)
    (done && override_active && ZONES <= 6) |-> ((relays & manual_flags) != 6'd0))
    else $error("override without an on manual zone");

endmodule

/* tb/tb.sv */
// tb: self-checking testbench for zone_relay_timer_scheduler_top
// depends on zrts_pkg and the rtl under rtl/, needs nothing else

module tb;
  import zrts_pkg::*;

  // codes the package leaves out: the two unused modes
  localparam logic [2:0] MODE_SPARE6 = 3'd6;
  localparam logic [2:0] MODE_SPARE7 = 3'd7;
  localparam int NZ = 6;
  localparam int NS = 16;
  localparam int ITEMS_PER_PHASE = 325;
  localparam int PHASES = 6;
  localparam int STALL_LIMIT = 4000;

  typedef struct {
    logic [2:0]  mode;
    logic [31:0] now;
    logic [5:0]  buttons;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [2:0]  weekday;
    logic [8:0]  yday;
    logic [2:0]  zone;
    logic        on;
    logic [22:0] dur;
    logic [3:0]  slot;
    logic [6:0]  days;
  } relay_cmd_t;

  typedef struct {
    logic [5:0] relays;
    logic [5:0] manuals;
    logic       ovr;
    logic       changed;
    logic [1:0] status;
  } relay_state_t;

  // directed row: typed rows carry their expected result
  typedef struct {
    relay_cmd_t   c;
    bit           typed;
    relay_state_t r;
  } cmd_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [3:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic start = 1'b0;
  logic busy;
  logic [2:0] mode = '0;
  logic [31:0] now_ms = '0;
  logic [5:0] buttons = '1;
  logic [4:0] hour = '0;
  logic [5:0] minute = '0;
  logic [2:0] weekday = '0;
  logic [8:0] year_day = '0;
  logic [2:0] zone = '0;
  logic turn_on = 1'b0;
  logic [22:0] on_secs = '0;
  logic [3:0] slot = '0;
  logic [6:0] days_mask = '0;
  logic done;
  logic [5:0] relays, manual_flags;
  logic override_active, state_changed;
  logic [1:0] status;

  always #5 clk = ~clk;

  zone_relay_timer_scheduler_top dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready),
    .start(start), .busy(busy),
    .mode(mode), .now_ms(now_ms), .buttons(buttons), .hour(hour), .minute(minute),
    .weekday(weekday), .year_day(year_day), .zone(zone), .turn_on(turn_on),
    .on_secs(on_secs), .slot(slot), .days_mask(days_mask),
    .done(done), .relays(relays), .manual_flags(manual_flags),
    .override_active(override_active), .state_changed(state_changed), .status(status)
  );

  // ---------------------------------------------------------------
  // predictor state: zones, buttons, slots and registers
  // ---------------------------------------------------------------
  bit          cfg_auto;
  logic [15:0] cfg_debounce;
  logic [22:0] cfg_mdef;
  logic [5:0]  cfg_tmask;

  bit          z_on[NZ], z_man[NZ];
  logic [31:0] z_deadline[NZ];
  bit          b_stable[NZ], b_last[NZ];
  logic [31:0] b_change[NZ];
  bit          s_valid[NS];
  logic [2:0]  s_zone[NS];
  logic [4:0]  s_hour[NS];
  logic [5:0]  s_minute[NS];
  logic [22:0] s_dur[NS];
  logic [6:0]  s_days[NS];
  logic [8:0]  s_last_day[NS];
  logic [10:0] last_minute;

  relay_state_t pending_results[$];
  int errors = 0;
  int results_seen = 0;
  int schedule_runs = 0;

  task automatic reset_predictor();
    cfg_auto = 1'b1;
    cfg_debounce = 16'd50;
    cfg_mdef = 23'd900;
    cfg_tmask = 6'd15;
    for (int i = 0; i < NZ; i++) begin
      z_on[i] = 0; z_man[i] = 0; z_deadline[i] = '0;
      b_stable[i] = 1; b_last[i] = 1; b_change[i] = '0;
    end
    for (int i = 0; i < NS; i++) begin
      s_valid[i] = 0;
      s_last_day[i] = NEVER_DAY;
    end
    last_minute = NO_MINUTE;
  endtask

  // one zone switched; returns 1 if on state, deadline or manual flag moved
  function automatic bit drive_zone(int z, bit on, logic [31:0] secs, bit man,
                                    logic [31:0] now);
    bit ch;
    logic [31:0] tgt, dl;
    ch = 0;
    if (z_on[z] != on) begin
      z_on[z] = on; ch = 1;
    end
    if (on) begin
      tgt = secs;
      dl = '0;
      if (z_man[z] != man) begin
        z_man[z] = man; ch = 1;
      end
      if (tgt == 0 && man && cfg_tmask[z]) tgt = cfg_mdef;
      if (tgt != 0) dl = now + tgt * MS_PER_S;
      if (z_deadline[z] != dl) begin
        z_deadline[z] = dl; ch = 1;
      end
    end else begin
      if (z_deadline[z] != 0) begin
        z_deadline[z] = '0; ch = 1;
      end
      if (z_man[z]) begin
        z_man[z] = 0; ch = 1;
      end
    end
    return ch;
  endfunction

  // next relay state and status for one accepted command
  function automatic relay_state_t apply_command(relay_cmd_t c);
    relay_state_t r;
    logic [31:0] diff;
    logic [10:0] mod;
    bit any, lvl;
    r = '{default: '0};
    if (c.mode == MODE_TICK || c.mode == MODE_TICK_TS) begin
      // expiry first, signed difference
      for (int i = 0; i < NZ; i++) begin
        diff = z_deadline[i] - c.now;
        if (z_deadline[i] != 0 && (diff == 0 || diff[31]))
          r.changed |= drive_zone(i, 0, 0, 0, c.now);
      end
      if (c.mode == MODE_TICK_TS && cfg_auto) begin
        any = 0;
        for (int i = 0; i < NS; i++) any |= s_valid[i];
        mod = c.hour * 11'd60 + c.minute;
        if (any && mod != last_minute) begin
          last_minute = mod;
          for (int i = 0; i < NS; i++) begin
            if (s_valid[i] && c.weekday <= 6 && s_days[i][c.weekday] &&
                s_hour[i] == c.hour && s_minute[i] == c.minute &&
                s_last_day[i] != c.yday) begin
              s_last_day[i] = c.yday;
              schedule_runs++;
              r.changed |= drive_zone(s_zone[i], 1, s_dur[i], 0, c.now);
            end
          end
        end
      end
      // debounce, a stable press toggles the zone
      for (int i = 0; i < NZ; i++) begin
        lvl = c.buttons[i];
        if (lvl != b_last[i]) begin
          b_last[i] = lvl; b_change[i] = c.now;
        end
        if ((c.now - b_change[i]) >= {16'd0, cfg_debounce} && lvl != b_stable[i]) begin
          b_stable[i] = lvl;
          if (!lvl) r.changed |= drive_zone(i, !z_on[i], 0, 1, c.now);
        end
      end
    end else if (c.mode == MODE_MANUAL) begin
      if (c.zone < NZ) r.changed = drive_zone(c.zone, c.on, c.dur, 1, c.now);
    end else if (c.mode == MODE_WRITE) begin
      if (c.zone >= NZ || c.hour > 23 || c.minute > 59 || c.dur == 0 || c.days == 0) begin
        r.status = ST_REJECT;
      end else begin
        s_zone[c.slot] = c.zone; s_hour[c.slot] = c.hour; s_minute[c.slot] = c.minute;
        s_dur[c.slot] = c.dur; s_days[c.slot] = c.days;
        s_valid[c.slot] = 1; s_last_day[c.slot] = NEVER_DAY;
      end
    end else if (c.mode == MODE_DELETE) begin
      if (!s_valid[c.slot]) r.status = ST_EMPTY;
      else s_valid[c.slot] = 0;
    end else if (c.mode == MODE_RESYNC) begin
      last_minute = NO_MINUTE;
      for (int i = 0; i < NS; i++) s_last_day[i] = NEVER_DAY;
    end
    for (int i = 0; i < NZ; i++) begin
      r.relays[i] = z_on[i];
      r.manuals[i] = z_man[i];
      r.ovr |= z_on[i] & z_man[i];
    end
    return r;
  endfunction

  // ---------------------------------------------------------------
  // result checking: every done cycle is one transfer
  // ---------------------------------------------------------------
  always @(posedge clk) begin
    relay_state_t e;
    if (!rst && done) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        $error("result with nothing expected");
        errors++;
      end else begin
        e = pending_results.pop_front();
        if (relays !== e.relays) begin
          $error("relays expected %h got %h", e.relays, relays); errors++;
        end
        if (manual_flags !== e.manuals) begin
          $error("manual_flags expected %h got %h", e.manuals, manual_flags); errors++;
        end
        if (override_active !== e.ovr) begin
          $error("override_active expected %b got %b", e.ovr, override_active); errors++;
        end
        if (state_changed !== e.changed) begin
          $error("state_changed expected %b got %b", e.changed, state_changed); errors++;
        end
        if (status !== e.status) begin
          $error("status expected %0d got %0d", e.status, status); errors++;
        end
      end
    end
  end

  // watchdog: cycles without any transfer
  int quiet_cycles = 0;
  always @(posedge clk) begin
    if (rst || (start && !busy) || done || (psel && penable)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("timeout with %0d results outstanding", pending_results.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------
  // drivers
  // ---------------------------------------------------------------
  // present one command, hold until the transfer, then queue its result
  task automatic send_cmd(relay_cmd_t c, bit typed = 0, relay_state_t typed_r = '{default: '0});
    relay_state_t r;
    mode <= c.mode; now_ms <= c.now; buttons <= c.buttons; hour <= c.hour;
    minute <= c.minute; weekday <= c.weekday; year_day <= c.yday; zone <= c.zone;
    turn_on <= c.on; on_secs <= c.dur; slot <= c.slot; days_mask <= c.days;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    r = apply_command(c);
    pending_results.insert(pending_results.size(), typed ? typed_r : r);
  endtask

  // register write while idle: setup then access cycle
  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= {idx, 2'b00}; pwdata <= val; penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      REG_AUTO:  cfg_auto = val[0];
      REG_DEB:   cfg_debounce = val[15:0];
      REG_MDEF:  cfg_mdef = val[22:0];
      REG_TMASK: cfg_tmask = val[5:0];
      default: ;
    endcase
  endtask

  // let every queued result come back, then the block settle
  task automatic drain();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  function automatic relay_cmd_t mk(logic [2:0] m, logic [31:0] t, logic [5:0] b,
                                    logic [4:0] h, logic [5:0] mi, logic [2:0] wd,
                                    logic [8:0] yd, logic [2:0] z, logic o,
                                    logic [22:0] d, logic [3:0] s, logic [6:0] dm);
    relay_cmd_t c;
    c.mode = m; c.now = t; c.buttons = b; c.hour = h; c.minute = mi; c.weekday = wd;
    c.yday = yd; c.zone = z; c.on = o; c.dur = d; c.slot = s; c.days = dm;
    return c;
  endfunction

  // ---------------------------------------------------------------
  // random stimulus: a running local clock with buttons and slots around it
  // ---------------------------------------------------------------
  logic [31:0] clk_ms;
  logic [4:0]  tod_hour;
  logic [5:0]  tod_min;
  logic [2:0]  tod_wd;
  logic [8:0]  tod_yd;
  logic [5:0]  btn_level;

  function automatic relay_cmd_t random_cmd();
    relay_cmd_t c;
    int pick;
    pick = $urandom_range(0, 99);
    c = mk(MODE_TICK_TS, clk_ms, btn_level, tod_hour, tod_min, tod_wd, tod_yd,
           3'($urandom_range(0, 5)), 1'($urandom_range(0, 1)), 23'($urandom_range(1, 90)),
           4'($urandom_range(0, 15)), 7'($urandom_range(1, 127)));
    if (pick < 62) begin
      // tick: advance wall clock and maybe the minute
      clk_ms += ($urandom_range(0, 49) == 0) ? $urandom : $urandom_range(0, 2500);
      if ($urandom_range(0, 3) == 0) begin
        tod_min++;
        if (tod_min == 60) begin
          tod_min = 0;
          tod_hour++;
          if (tod_hour == 24) begin
            tod_hour = 0;
            tod_wd = (tod_wd == 6) ? 3'd0 : tod_wd + 3'd1;
            tod_yd = (tod_yd == 365) ? 9'd0 : tod_yd + 9'd1;
          end
        end
      end
      if ($urandom_range(0, 5) == 0) btn_level[$urandom_range(0, 5)] ^= 1'b1;
      c.now = clk_ms; c.buttons = btn_level; c.hour = tod_hour; c.minute = tod_min;
      c.weekday = tod_wd; c.yday = tod_yd;
      c.mode = ($urandom_range(0, 6) == 0) ? MODE_TICK : MODE_TICK_TS;
    end else if (pick < 72) begin
      c.mode = MODE_MANUAL;
      c.zone = 3'($urandom_range(0, 7));
      c.dur = ($urandom_range(0, 2) == 0) ? 23'd0 : 23'($urandom_range(1, 120));
    end else if (pick < 84) begin
      // well-formed slot near the current time so that it fires
      c.mode = MODE_WRITE;
      c.minute = (tod_min > 57) ? 6'd59 : 6'(tod_min + $urandom_range(0, 2));
      if ($urandom_range(0, 1)) c.days[tod_wd] = 1'b1;
    end else if (pick < 90) begin
      c.mode = MODE_DELETE;
    end else if (pick < 93) begin
      c.mode = MODE_RESYNC;
    end else begin
      // noise over every field
      c = mk(3'($urandom_range(0, 7)), $urandom, 6'($urandom), 5'($urandom), 6'($urandom),
             3'($urandom), 9'($urandom), 3'($urandom), 1'($urandom), 23'($urandom),
             4'($urandom), 7'($urandom));
    end
    return c;
  endfunction

  // ---------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------
  cmd_row_t rows[$];
  relay_state_t quiet_ok = '{default: '0};
  relay_state_t rej = '{status: ST_REJECT, default: '0};
  relay_state_t empty = '{status: ST_EMPTY, default: '0};

  task automatic add_row(cmd_row_t row);
    rows.insert(rows.size(), row);
  endtask

  initial begin
    int idle_pct;
    reset_predictor();
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed part: extremes, every mode, each special case
    add_row('{mk(MODE_TICK, 0, '1, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1, quiet_ok});
    add_row('{mk(MODE_DELETE, 5, '1, 0, 0, 0, 0, 0, 0, 0, 3, 0), 1, empty});
    add_row('{mk(MODE_WRITE, 5, '1, 8, 30, 0, 0, 6, 0, 60, 0, 127), 1, rej});
    add_row('{mk(MODE_WRITE, 5, '1, 8, 30, 0, 0, 7, 0, 60, 0, 127), 1, rej});
    add_row('{mk(MODE_WRITE, 5, '1, 24, 30, 0, 0, 1, 0, 60, 0, 127), 1, rej});
    add_row('{mk(MODE_WRITE, 5, '1, 8, 60, 0, 0, 1, 0, 60, 0, 127), 1, rej});
    add_row('{mk(MODE_WRITE, 5, '1, 8, 30, 0, 0, 1, 0, 0, 0, 127), 1, rej});
    add_row('{mk(MODE_WRITE, 5, '1, 8, 30, 0, 0, 1, 0, 60, 0, 0), 1, rej});
    add_row('{mk(MODE_WRITE, 5, '1, 8, 30, 0, 0, 1, 0, 60, 0, 127), 1, quiet_ok});
    add_row('{mk(MODE_WRITE, 5, '1, 23, 59, 0, 0, 5, 0, '1, 15, 1), 1, quiet_ok});
    // schedule runs zone 1, then the same minute does not run again
    add_row('{mk(MODE_TICK_TS, 1000, '1, 8, 30, 2, 10, 0, 0, 0, 0, 0), 0, quiet_ok});
    add_row('{mk(MODE_TICK_TS, 1500, '1, 8, 30, 2, 10, 0, 0, 0, 0, 0), 0, quiet_ok});
    add_row('{mk(MODE_TICK_TS, 2000, '1, 8, 31, 7, 10, 0, 0, 0, 0, 0), 0, quiet_ok});
    // manual default on a timed zone, unlimited on an untimed one, bad zone
    add_row('{mk(MODE_MANUAL, 3000, '1, 0, 0, 0, 0, 0, 1, 0, 0, 0), 0, quiet_ok});
    add_row('{mk(MODE_MANUAL, 3000, '1, 0, 0, 0, 0, 5, 1, 0, 0, 0), 0, quiet_ok});
    add_row('{mk(MODE_MANUAL, 3000, '1, 0, 0, 0, 0, 7, 1, 0, 0, 0), 0, quiet_ok});
    add_row('{mk(MODE_MANUAL, 3100, '1, 0, 0, 0, 0, 0, 0, 0, 0, 0), 0, quiet_ok});
    // deadline of the scheduled zone passes
    add_row('{mk(MODE_TICK, 61000, '1, 0, 0, 0, 0, 0, 0, 0, 0, 0), 0, quiet_ok});
    add_row('{mk(MODE_SPARE6, '1, '0, '1, '1, '1, '1, '1, 1, '1, '1, '1), 0, quiet_ok});
    add_row('{mk(MODE_SPARE7, 0, '1, 0, 0, 0, 0, 0, 0, 0, 0, 0), 0, quiet_ok});
    add_row('{mk(MODE_RESYNC, 0, '1, 0, 0, 0, 0, 0, 0, 0, 0, 0), 0, quiet_ok});
    // year day equal to the never-run mark
    add_row('{mk(MODE_TICK_TS, 62000, '1, 8, 30, 1, 511, 0, 0, 0, 0, 0), 0, quiet_ok});
    // press every button, hold past debounce, wrap the millisecond counter
    add_row('{mk(MODE_TICK, 32'hFFFF_FFF0, '0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 0, quiet_ok});
    add_row('{mk(MODE_TICK, 32'h0000_0100, '0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 0, quiet_ok});
    add_row('{mk(MODE_DELETE, 0, '1, 0, 0, 0, 0, 0, 0, 0, 0, 0), 0, quiet_ok});
    foreach (rows[i]) send_cmd(rows[i].c, rows[i].typed, rows[i].r);
    drain();

    clk_ms = 32'd500;
    tod_hour = 8; tod_min = 0; tod_wd = 3; tod_yd = 100;
    btn_level = '1;

    // random phases, each with its own register setting
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: begin
          write_reg(REG_AUTO, 1); write_reg(REG_DEB, 0);
          write_reg(REG_MDEF, 0); write_reg(REG_TMASK, 6'h3F);
        end
        1: begin
          write_reg(REG_DEB, 16'hFFFF); write_reg(REG_MDEF, 23'h7F_FFFF);
          write_reg(REG_TMASK, 0);
        end
        2: begin
          write_reg(REG_AUTO, 0); write_reg(REG_DEB, $urandom_range(0, 300));
          write_reg(REG_MDEF, $urandom_range(1, 200));
        end
        3: begin
          write_reg(REG_AUTO, 1); write_reg(REG_TMASK, $urandom_range(0, 63));
          write_reg(REG_MDEF, $urandom);
        end
        default: begin
          write_reg(REG_DEB, $urandom_range(0, 2000));
          write_reg(REG_MDEF, $urandom_range(1, 100));
          write_reg(REG_TMASK, $urandom_range(0, 63));
        end
      endcase
      // sender idles rarely, then often, then not at all
      idle_pct = (p < 2) ? 8 : (p < 4) ? 71 : 0;
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        send_cmd(random_cmd());
        if ($urandom_range(1, 100) <= idle_pct) begin
          start <= 1'b0;
          repeat ($urandom_range(1, 40)) @(posedge clk);
        end
      end
      // hold off until every result is back before touching registers
      drain();
    end

    $display("covered %0d results incl. %0d schedule runs over %0d register settings",
             results_seen, schedule_runs, PHASES + 1);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d mismatches", errors);
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
